### hdl/priority_aging_scheduler_assert.svh
// assertion macros for the priority aging scheduler
`ifndef PRIORITY_AGING_SCHEDULER_ASSERT_SVH
`define PRIORITY_AGING_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pas_pkg.sv
// shared types, constants and codes of the priority aging scheduler
package pas_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int TIME_BITS  = 32;
    localparam int LEVEL_BITS = 4;
    localparam int RUN_BITS   = 16;
    localparam int ID_BITS    = 32;

    localparam logic [2:0] ACT_ALLOC     = 3'd0;
    localparam logic [2:0] ACT_SET_STATE = 3'd1;
    localparam logic [2:0] ACT_SET_LEVEL = 3'd2;
    localparam logic [2:0] ACT_PASS      = 3'd3;
    localparam logic [2:0] ACT_RUN_END   = 3'd4;

    localparam logic [2:0] SS_UNUSED   = 3'd0;
    localparam logic [2:0] SS_USED     = 3'd1;
    localparam logic [2:0] SS_RUNNABLE = 3'd3;
    localparam logic [2:0] SS_RUNNING  = 3'd4;
    localparam logic [2:0] SS_ZOMBIE   = 3'd5;

    localparam logic [1:0] RS_DONE = 2'd0;
    localparam logic [1:0] RS_NONE = 2'd1;
    localparam logic [1:0] RS_BAD  = 2'd2;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_SWEEP = 3'd1;
    localparam logic [2:0] OP_PICK  = 3'd2;
    localparam logic [2:0] OP_STATE = 3'd3;
    localparam logic [2:0] OP_LEVEL = 3'd4;
    localparam logic [2:0] OP_RUN   = 3'd5;

    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_PERIOD    = 3'd1;
    localparam logic [2:0] CFG_USE_LIMIT = 3'd2;
    localparam logic [2:0] CFG_LOWEST    = 3'd3;
    localparam logic [2:0] CFG_HIGHEST   = 3'd4;
    localparam logic [2:0] CFG_DEFAULT   = 3'd5;

    typedef struct packed {
        logic [2:0]            state;
        logic [LEVEL_BITS-1:0] cur;
        logic [LEVEL_BITS-1:0] base;
        logic [TIME_BITS-1:0]  wait_since;
        logic [RUN_BITS-1:0]   run_count;
        logic [ID_BITS-1:0]    slot_id;
    } slot_row_t;

    typedef struct packed {
        logic [31:0]           age_limit;
        logic [15:0]           aging_period;
        logic [15:0]           cpu_use_limit;
        logic [LEVEL_BITS-1:0] lowest_level;
        logic [LEVEL_BITS-1:0] highest_level;
        logic [LEVEL_BITS-1:0] default_level;
    } cfg_t;

    typedef struct packed {
        logic unused;
        logic compete;
        logic bad;
    } alu_flags_t;

endpackage

### hdl/pas_req_if.sv
// request channel carrying one scheduler action
interface pas_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [5:0]  slot;
    logic [2:0]  new_state;
    logic        stamp_wait;
    logic [3:0]  level;
    logic [31:0] now;

    modport source (output valid, action, slot, new_state, stamp_wait, level, now,
                    input ready);
    modport sink   (input valid, action, slot, new_state, stamp_wait, level, now,
                    output ready);
endinterface

### hdl/pas_rsp_if.sv
// response channel carrying one scheduler result
interface pas_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  chosen_slot;
    logic [31:0] task_id;
    logic [3:0]  chosen_level;

    modport source (output valid, status, chosen_slot, task_id, chosen_level, input ready);
    modport sink   (input valid, status, chosen_slot, task_id, chosen_level, output ready);
endinterface

### hdl/pas_slot_alu.sv
// shared slot update unit: one table row in, its updated row out
module pas_slot_alu
    import pas_pkg::*;
(
    input  logic [2:0]           op,
    input  slot_row_t            row_in,
    input  cfg_t                 cfg,
    input  logic                 age_en,
    input  logic [2:0]           new_state,
    input  logic                 stamp_wait,
    input  logic [LEVEL_BITS-1:0] level,
    input  logic [TIME_BITS-1:0] now,
    input  logic [ID_BITS-1:0]   next_id,
    output slot_row_t            row_out,
    output alu_flags_t           flags
);

    slot_row_t            aged;
    logic [TIME_BITS-1:0] waited;
    logic [RUN_BITS-1:0]  run_inc;

    always_comb
    begin
        row_out = row_in;
        aged    = row_in;
        waited  = now - row_in.wait_since;
        run_inc = row_in.run_count;
        unique case (op)
            OP_ALLOC:
            begin
                row_out.state      = SS_USED;
                row_out.cur        = cfg.default_level;
                row_out.base       = cfg.default_level;
                row_out.wait_since = '0;
                row_out.run_count  = '0;
                row_out.slot_id    = next_id;
            end
            OP_SWEEP:
            begin
                // aging first, then wait tracking on the aged row
                if (age_en && row_in.state == SS_RUNNABLE && row_in.cur > cfg.highest_level
                    && waited > cfg.age_limit)
                begin
                    aged.cur        = row_in.cur - 1'b1;
                    aged.wait_since = now;
                end
                row_out = aged;
                if (aged.state == SS_RUNNABLE && aged.wait_since == '0)
                    row_out.wait_since = now;
                else if (aged.state == SS_RUNNING)
                    row_out.wait_since = '0;
            end
            OP_PICK:
            begin
                row_out.state = SS_RUNNING;
                if (row_in.cur < row_in.base)
                    row_out.cur = row_in.base;
            end
            OP_STATE:
            begin
                if (new_state <= SS_ZOMBIE)
                begin
                    row_out.state = new_state;
                    if (new_state == SS_RUNNABLE && stamp_wait)
                        row_out.wait_since = now;
                end
            end
            OP_LEVEL:
            begin
                if (level <= cfg.lowest_level)
                begin
                    row_out.cur  = level;
                    row_out.base = level;
                end
            end
            OP_RUN:
            begin
                if (row_in.run_count != '1)
                    run_inc = row_in.run_count + 1'b1;
                row_out.run_count = run_inc;
                if (run_inc > cfg.cpu_use_limit && row_in.cur < cfg.lowest_level)
                    row_out.cur = row_in.cur + 1'b1;
            end
            default: ;
        endcase
        flags.unused  = (row_in.state == SS_UNUSED);
        flags.compete = (row_out.state == SS_RUNNABLE) && (row_out.cur <= cfg.lowest_level);
        flags.bad     = ((op == OP_STATE) && (new_state > SS_ZOMBIE))
                     || ((op == OP_LEVEL) && (level > cfg.lowest_level));
    end

endmodule

### hdl/priority_aging_scheduler.sv
// priority aging scheduler top level: slot table, sequencer and channels
// The scheduler keeps 64 task slots in one table memory (one row per slot, read registered)
// and serves one transaction at a time. Every slot visit is a read step and then a
// write step through the shared slot update unit, so the memory port sets the pace: a
// scheduling pass sweeps all slots and then updates the chosen slot, if one was found;
// an allocation scans until the first unused slot; set state, set priority and run ended
// visit the one slot named. Slots read as unused with zero levels, wait and count after
// reset through one valid bit per row, so no clearing pass is needed. A finished result
// sits in an output register; the next transaction is accepted while it waits to be taken.
`include "priority_aging_scheduler_assert.svh"

module priority_aging_scheduler
    import pas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pas_req_if.sink     req,
    pas_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ALLOC_RD = 4'd1;
    localparam logic [3:0] S_ALLOC_WR = 4'd2;
    localparam logic [3:0] S_PASS_RD  = 4'd3;
    localparam logic [3:0] S_PASS_WR  = 4'd4;
    localparam logic [3:0] S_PICK_RD  = 4'd5;
    localparam logic [3:0] S_PICK_WR  = 4'd6;
    localparam logic [3:0] S_SLOT_RD  = 4'd7;
    localparam logic [3:0] S_SLOT_WR  = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    // configuration registers
    cfg_t cfg_reg;

    // sequencer and scheduler state
    logic [3:0]            fsm_reg, fsm_next;
    logic [SLOT_BITS-1:0]  idx_reg, idx_next;
    logic [ID_BITS-1:0]    next_id_reg, next_id_next;
    logic [15:0]           pass_count_reg, pass_count_next;
    logic                  age_en_reg, age_en_next;
    logic                  pick_valid_reg, pick_valid_next;
    logic [SLOT_BITS-1:0]  pick_slot_reg, pick_slot_next;

    // selection trackers for the current pass
    logic                  found_reg, found_next;
    logic [LEVEL_BITS-1:0] best_reg, best_next;
    logic [SLOT_BITS-1:0]  first_reg, first_next;
    logic                  multi_reg, multi_next;
    logic                  last_in_reg, last_in_next;
    logic                  after_ok_reg, after_ok_next;
    logic [SLOT_BITS-1:0]  after_reg, after_next;

    // latched transaction
    logic [2:0]            act_reg;
    logic [2:0]            ns_reg;
    logic                  stamp_reg;
    logic [LEVEL_BITS-1:0] lvl_reg;
    logic [TIME_BITS-1:0]  now_reg;

    // result waiting for the output register
    logic [1:0]            res_status_reg, res_status_next;
    logic [SLOT_BITS-1:0]  res_slot_reg, res_slot_next;
    logic [ID_BITS-1:0]    res_id_reg, res_id_next;
    logic [LEVEL_BITS-1:0] res_level_reg, res_level_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg;
    logic [SLOT_BITS-1:0]  out_slot_reg;
    logic [ID_BITS-1:0]    out_id_reg;
    logic [LEVEL_BITS-1:0] out_level_reg;

    // slot table memory with per-row valid bits
    slot_row_t             table_mem [SLOTS];
    logic [SLOTS-1:0]      row_valid_reg;
    slot_row_t             rd_data_reg;
    logic                  rd_valid_reg;
    slot_row_t             row_in;
    slot_row_t             row_out;
    logic                  mem_we;
    alu_flags_t            flags;
    logic [2:0]            alu_op;

    logic                  accept;
    logic                  out_load;
    logic                  idx_last;
    logic [15:0]           pass_inc;

    assign accept   = req.valid && req.ready;
    assign req.ready = (fsm_reg == S_IDLE);
    assign out_load = (fsm_reg == S_FINISH) && (!out_valid_reg || rsp.ready);
    assign idx_last = (idx_reg == SLOT_BITS'(SLOTS - 1));
    assign pass_inc = pass_count_reg + 1'b1;
    assign row_in   = rd_valid_reg ? rd_data_reg : '0;

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.chosen_slot  = out_slot_reg;
    assign rsp.task_id      = out_id_reg;
    assign rsp.chosen_level = out_level_reg;

    // operation of the shared unit follows the sequencer step
    always_comb
    begin
        unique case (fsm_reg)
            S_ALLOC_WR: alu_op = OP_ALLOC;
            S_PASS_WR:  alu_op = OP_SWEEP;
            S_PICK_WR:  alu_op = OP_PICK;
            default:
            begin
                unique case (act_reg)
                    ACT_SET_STATE: alu_op = OP_STATE;
                    ACT_SET_LEVEL: alu_op = OP_LEVEL;
                    default:       alu_op = OP_RUN;
                endcase
            end
        endcase
    end

    pas_slot_alu u_alu (
        .op         (alu_op),
        .row_in     (row_in),
        .cfg        (cfg_reg),
        .age_en     (age_en_reg),
        .new_state  (ns_reg),
        .stamp_wait (stamp_reg),
        .level      (lvl_reg),
        .now        (now_reg),
        .next_id    (next_id_reg),
        .row_out    (row_out),
        .flags      (flags)
    );

    // sequencer
    always_comb
    begin
        fsm_next        = fsm_reg;
        idx_next        = idx_reg;
        next_id_next    = next_id_reg;
        pass_count_next = pass_count_reg;
        age_en_next     = age_en_reg;
        pick_valid_next = pick_valid_reg;
        pick_slot_next  = pick_slot_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        first_next      = first_reg;
        multi_next      = multi_reg;
        last_in_next    = last_in_reg;
        after_ok_next   = after_ok_reg;
        after_next      = after_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_id_next     = res_id_reg;
        res_level_next  = res_level_reg;
        mem_we          = 1'b0;

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = RS_DONE;
                    res_slot_next   = '0;
                    res_id_next     = '0;
                    res_level_next  = '0;
                    idx_next        = '0;
                    if (req.action == ACT_ALLOC)
                        fsm_next = S_ALLOC_RD;
                    else if (req.action == ACT_PASS)
                    begin
                        // aging cadence: the count clears when it reaches the period
                        found_next = 1'b0;
                        if (pass_inc >= cfg_reg.aging_period)
                        begin
                            pass_count_next = '0;
                            age_en_next     = 1'b1;
                        end
                        else
                        begin
                            pass_count_next = pass_inc;
                            age_en_next     = 1'b0;
                        end
                        fsm_next = S_PASS_RD;
                    end
                    else if (req.action > ACT_RUN_END
                             || {1'b0, req.slot} >= 7'(SLOTS))
                    begin
                        res_status_next = RS_NONE;
                        fsm_next        = S_FINISH;
                    end
                    else
                    begin
                        idx_next = SLOT_BITS'(req.slot);
                        fsm_next = S_SLOT_RD;
                    end
                end
            end
            S_ALLOC_RD: fsm_next = S_ALLOC_WR;
            S_ALLOC_WR:
            begin
                if (flags.unused)
                begin
                    mem_we          = 1'b1;
                    res_slot_next   = idx_reg;
                    res_id_next     = next_id_reg;
                    res_level_next  = cfg_reg.default_level;
                    next_id_next    = next_id_reg + 1'b1;
                    fsm_next        = S_FINISH;
                end
                else if (idx_last)
                begin
                    res_status_next = RS_NONE;
                    fsm_next        = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    fsm_next = S_ALLOC_RD;
                end
            end
            S_PASS_RD: fsm_next = S_PASS_WR;
            S_PASS_WR:
            begin
                mem_we = 1'b1;
                // running minimum with round-robin bookkeeping
                if (flags.compete)
                begin
                    if (!found_reg || row_out.cur < best_reg)
                    begin
                        found_next    = 1'b1;
                        best_next     = row_out.cur;
                        first_next    = idx_reg;
                        multi_next    = 1'b0;
                        last_in_next  = pick_valid_reg && (idx_reg == pick_slot_reg);
                        after_ok_next = pick_valid_reg && (idx_reg > pick_slot_reg);
                        after_next    = idx_reg;
                    end
                    else if (row_out.cur == best_reg)
                    begin
                        multi_next = 1'b1;
                        if (pick_valid_reg && idx_reg == pick_slot_reg)
                            last_in_next = 1'b1;
                        if (!after_ok_reg && pick_valid_reg && idx_reg > pick_slot_reg)
                        begin
                            after_ok_next = 1'b1;
                            after_next    = idx_reg;
                        end
                    end
                end
                if (idx_last)
                begin
                    if (!found_next)
                    begin
                        res_status_next = RS_NONE;
                        fsm_next        = S_FINISH;
                    end
                    else
                    begin
                        idx_next = (multi_next && last_in_next && after_ok_next)
                                 ? after_next : first_next;
                        fsm_next = S_PICK_RD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    fsm_next = S_PASS_RD;
                end
            end
            S_PICK_RD: fsm_next = S_PICK_WR;
            S_PICK_WR:
            begin
                mem_we          = 1'b1;
                pick_valid_next = 1'b1;
                pick_slot_next  = idx_reg;
                res_slot_next   = idx_reg;
                res_id_next     = row_out.slot_id;
                res_level_next  = row_out.cur;
                fsm_next        = S_FINISH;
            end
            S_SLOT_RD: fsm_next = S_SLOT_WR;
            S_SLOT_WR:
            begin
                if (flags.bad)
                    res_status_next = RS_BAD;
                else
                    mem_we = 1'b1;
                fsm_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                    fsm_next = S_IDLE;
            end
            default: fsm_next = S_IDLE;
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_IDLE;
            idx_reg        <= '0;
            next_id_reg    <= ID_BITS'(1);
            pass_count_reg <= '0;
            age_en_reg     <= 1'b0;
            pick_valid_reg <= 1'b0;
            pick_slot_reg  <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            first_reg      <= '0;
            multi_reg      <= 1'b0;
            last_in_reg    <= 1'b0;
            after_ok_reg   <= 1'b0;
            after_reg      <= '0;
            out_valid_reg  <= 1'b0;
            row_valid_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            cfg_reg.age_limit       <= 32'd1000000;
            cfg_reg.aging_period    <= 16'd10;
            cfg_reg.cpu_use_limit   <= 16'd500;
            cfg_reg.lowest_level    <= 4'd3;
            cfg_reg.highest_level   <= 4'd0;
            cfg_reg.default_level   <= 4'd1;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            idx_reg        <= idx_next;
            next_id_reg    <= next_id_next;
            pass_count_reg <= pass_count_next;
            age_en_reg     <= age_en_next;
            pick_valid_reg <= pick_valid_next;
            pick_slot_reg  <= pick_slot_next;
            found_reg      <= found_next;
            best_reg       <= best_next;
            first_reg      <= first_next;
            multi_reg      <= multi_next;
            last_in_reg    <= last_in_next;
            after_ok_reg   <= after_ok_next;
            after_reg      <= after_next;
            out_valid_reg  <= out_valid_next;
            rd_valid_reg   <= row_valid_reg[idx_reg];
            if (mem_we)
                row_valid_reg[idx_reg] <= 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: cfg_reg.age_limit       <= cfg_data;
                    CFG_PERIOD:    cfg_reg.aging_period    <= cfg_data[15:0];
                    CFG_USE_LIMIT: cfg_reg.cpu_use_limit   <= cfg_data[15:0];
                    CFG_LOWEST:    cfg_reg.lowest_level    <= cfg_data[LEVEL_BITS-1:0];
                    CFG_HIGHEST:   cfg_reg.highest_level   <= cfg_data[LEVEL_BITS-1:0];
                    CFG_DEFAULT:   cfg_reg.default_level   <= cfg_data[LEVEL_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers and table memory
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= req.action;
            ns_reg    <= req.new_state;
            stamp_reg <= req.stamp_wait;
            lvl_reg   <= req.level;
            now_reg   <= TIME_BITS'(req.now);
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_id_reg     <= res_id_next;
        res_level_reg  <= res_level_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_id_reg     <= res_id_reg;
            out_level_reg  <= res_level_reg;
        end
        if (mem_we)
            table_mem[idx_reg] <= row_out;
        rd_data_reg <= table_mem[idx_reg];
    end

    // table writes only happen on the write half of a slot visit
    `PAS_ASSERT_NOW(a_we_in_write_step, mem_we,
        fsm_reg == S_ALLOC_WR || fsm_reg == S_PASS_WR || fsm_reg == S_PICK_WR
        || fsm_reg == S_SLOT_WR, "table write outside a write step")

    // an accepted transaction always starts work
    `PAS_ASSERT_NEXT(a_accept_leaves_idle, accept, fsm_reg != S_IDLE,
        "accepted transaction left the sequencer idle")

    // a loaded result is presented on the next cycle
    `PAS_ASSERT_NEXT(a_result_presented, out_load, rsp.valid,
        "finished result not presented")

    // a pick always records the chosen slot as the last pick
    `PAS_ASSERT_NEXT(a_pick_recorded, fsm_reg == S_PICK_WR,
        pick_valid_reg && pick_slot_reg == $past(idx_reg), "pick not recorded")

endmodule

### bench/tb.sv
// self-checking testbench of the priority aging scheduler
module tb;
    import pas_pkg::*;

    // one scheduler action as offered on the request channel
    typedef struct {
        logic [2:0]  action;
        logic [5:0]  slot;
        logic [2:0]  new_state;
        logic        stamp_wait;
        logic [3:0]  level;
        logic [31:0] now;
    } sched_op_t;

    // one scheduler answer as seen on the response channel
    typedef struct {
        logic [1:0]  status;
        logic [5:0]  chosen_slot;
        logic [31:0] task_id;
        logic [3:0]  chosen_level;
    } sched_ans_t;

    // directed row: the answer is typed in only where known_ans is set
    typedef struct {
        sched_op_t  op;
        logic       known_ans;
        sched_ans_t ans;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    pas_req_if req_ch ();
    pas_rsp_if rsp_ch ();

    priority_aging_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the slot table and the settings
    logic [2:0]  shadow_state [SLOTS];
    logic [3:0]  shadow_cur   [SLOTS];
    logic [3:0]  shadow_base  [SLOTS];
    logic [31:0] shadow_wait  [SLOTS];
    logic [15:0] shadow_runs  [SLOTS];
    logic [31:0] shadow_id    [SLOTS];
    logic        ever_alloc   [SLOTS];
    logic [31:0] shadow_next_id;
    logic        last_pick_ok;
    logic [5:0]  last_pick_slot;
    logic [15:0] shadow_passes;
    logic [31:0] set_threshold;
    logic [15:0] set_period;
    logic [15:0] set_use_limit;
    logic [3:0]  set_lowest;
    logic [3:0]  set_highest;
    logic [3:0]  set_default;

    sched_ans_t answers_due [$];
    int         mismatches;
    int         answers_seen;
    int         picks_seen;
    int         items_sent;

    // typed answer for the next offered transaction, when set
    logic       typed_ok;
    sched_ans_t typed_ans;

    // receiver long hold-off request, toggled by the stimulus process
    logic hold_flip;
    logic hold_seen;
    int   hold_left;
    int   stall_phase;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // overall limit on run length
    initial
    begin
        #(20 * 6000000);
        $display("priority_aging_scheduler: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction of the scheduler
    // ------------------------------------------------------------------

    // slot to run next, or SLOTS when no runnable slot is at a legal level
    function automatic int choose_slot();
        int best;
        int first;
        int after;
        int count;
        logic last_in;
        best = 16;
        first = SLOTS;
        after = SLOTS;
        count = 0;
        last_in = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_state[i] == SS_RUNNABLE && shadow_cur[i] <= set_lowest
                && shadow_cur[i] < best)
                best = shadow_cur[i];
        end
        if (best > 15)
            return SLOTS;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_state[i] == SS_RUNNABLE && shadow_cur[i] == best)
            begin
                count++;
                if (first == SLOTS)
                    first = i;
                if (last_pick_ok && i == last_pick_slot)
                    last_in = 1'b1;
                if (last_pick_ok && i > last_pick_slot && after == SLOTS)
                    after = i;
            end
        end
        // round robin: move past the last pick when it is among the winners
        if (count > 1 && last_in && after != SLOTS)
            return after;
        return first;
    endfunction

    function automatic sched_ans_t sched_predict(sched_op_t op);
        sched_ans_t a;
        int         pick;
        logic [31:0] waited;
        a = '{RS_DONE, 6'd0, 32'd0, 4'd0};
        case (op.action)
            ACT_ALLOC:
            begin
                a.status = RS_NONE;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (shadow_state[i] == SS_UNUSED)
                    begin
                        shadow_id[i] = shadow_next_id;
                        shadow_next_id = shadow_next_id + 32'd1;
                        shadow_state[i] = SS_USED;
                        shadow_cur[i] = set_default;
                        shadow_base[i] = set_default;
                        shadow_runs[i] = '0;
                        shadow_wait[i] = '0;
                        ever_alloc[i] = 1'b1;
                        a = '{RS_DONE, 6'(i), shadow_id[i], set_default};
                        break;
                    end
                end
            end
            ACT_PASS:
            begin
                shadow_passes = shadow_passes + 16'd1;
                if (shadow_passes >= set_period)
                begin
                    shadow_passes = '0;
                    // aging sweep
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        waited = op.now - shadow_wait[i];
                        if (shadow_state[i] == SS_RUNNABLE && shadow_cur[i] > set_highest
                            && waited > set_threshold)
                        begin
                            shadow_cur[i] = shadow_cur[i] - 4'd1;
                            shadow_wait[i] = op.now;
                        end
                    end
                end
                // wait tracking
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (shadow_state[i] == SS_RUNNABLE && shadow_wait[i] == 0)
                        shadow_wait[i] = op.now;
                    else if (shadow_state[i] == SS_RUNNING)
                        shadow_wait[i] = '0;
                end
                pick = choose_slot();
                if (pick == SLOTS)
                    a.status = RS_NONE;
                else
                begin
                    last_pick_ok = 1'b1;
                    last_pick_slot = 6'(pick);
                    shadow_state[pick] = SS_RUNNING;
                    if (shadow_cur[pick] < shadow_base[pick])
                        shadow_cur[pick] = shadow_base[pick];
                    a = '{RS_DONE, 6'(pick), shadow_id[pick], shadow_cur[pick]};
                end
            end
            ACT_SET_STATE:
            begin
                if (op.new_state > SS_ZOMBIE)
                    a.status = RS_BAD;
                else
                begin
                    shadow_state[op.slot] = op.new_state;
                    if (op.new_state == SS_RUNNABLE && op.stamp_wait)
                        shadow_wait[op.slot] = op.now;
                end
            end
            ACT_SET_LEVEL:
            begin
                if (op.level > set_lowest)
                    a.status = RS_BAD;
                else
                begin
                    shadow_cur[op.slot] = op.level;
                    shadow_base[op.slot] = op.level;
                end
            end
            ACT_RUN_END:
            begin
                if (shadow_runs[op.slot] != 16'hFFFF)
                    shadow_runs[op.slot] = shadow_runs[op.slot] + 16'd1;
                if (shadow_runs[op.slot] > set_use_limit && shadow_cur[op.slot] < set_lowest)
                    shadow_cur[op.slot] = shadow_cur[op.slot] + 4'd1;
            end
            default:
                a.status = RS_NONE;
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // response side: stall pattern and checking
    // ------------------------------------------------------------------

    // stalls come in phases: free-flowing, light, heavy; plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_seen    <= 1'b0;
            hold_left    <= 0;
            stall_phase  <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 900;
            if (hold_flip != hold_seen)
            begin
                hold_seen    <= hold_flip;
                hold_left    <= 700;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_phase < 300)
                rsp_ch.ready <= 1'b1;
            else if (stall_phase < 600)
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                rsp_ch.ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // compare each accepted response with the oldest answer due
    always @(posedge clk)
    begin
        sched_ans_t due;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            answers_seen++;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d slot %0d id %0h level %0d",
                             rsp_ch.status, rsp_ch.chosen_slot, rsp_ch.task_id,
                             rsp_ch.chosen_level);
            end
            else
            begin
                due = answers_due.pop_front();
                if (due.status == RS_DONE && rsp_ch.status == RS_DONE && due.task_id != 0)
                    picks_seen++;
                if (rsp_ch.status !== due.status || rsp_ch.chosen_slot !== due.chosen_slot
                    || rsp_ch.task_id !== due.task_id
                    || rsp_ch.chosen_level !== due.chosen_level)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response %0d: want status %0d slot %0d id %0h level %0d, got status %0d slot %0d id %0h level %0d",
                                 answers_seen, due.status, due.chosen_slot, due.task_id,
                                 due.chosen_level, rsp_ch.status, rsp_ch.chosen_slot,
                                 rsp_ch.task_id, rsp_ch.chosen_level);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    int burst_left;

    // offer one transaction, predict it on acceptance, then maybe idle
    task automatic offer(sched_op_t op);
        int         gap;
        sched_ans_t pred;
        req_ch.valid      <= 1'b1;
        req_ch.action     <= op.action;
        req_ch.slot       <= op.slot;
        req_ch.new_state  <= op.new_state;
        req_ch.stamp_wait <= op.stamp_wait;
        req_ch.level      <= op.level;
        req_ch.now        <= op.now;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pred = sched_predict(op);
        // the typed answer replaces the predicted one
        if (typed_ok)
            pred = typed_ans;
        answers_due.push_back(pred);
        items_sent++;
        // bursts of random length separated by random gaps
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let everything drain before touching the settings
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write all six registers in index order, block idle
    task automatic apply_settings(logic [31:0] thr, logic [15:0] per, logic [15:0] lim,
                                  logic [3:0] lo, logic [3:0] hi, logic [3:0] dflt);
        logic [31:0] vals [6];
        vals = '{thr, 32'(per), 32'(lim), 32'(lo), 32'(hi), 32'(dflt)};
        for (int i = CFG_THRESHOLD; i <= CFG_DEFAULT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        set_threshold = thr;
        set_period    = per;
        set_use_limit = lim;
        set_lowest    = lo;
        set_highest   = hi;
        set_default   = dflt;
        @(posedge clk);
    endtask

    logic [31:0] clock_now;

    // random transaction, mostly well-formed scheduling traffic
    function automatic sched_op_t random_op();
        sched_op_t op;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            op.action = ACT_ALLOC;
        else if (pick < 42)
            op.action = ACT_SET_STATE;
        else if (pick < 54)
            op.action = ACT_SET_LEVEL;
        else if (pick < 82)
            op.action = ACT_PASS;
        else if (pick < 97)
            op.action = ACT_RUN_END;
        else
            op.action = 3'($urandom_range(5, 7));
        op.slot = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 3) != 0)
            op.new_state = SS_RUNNABLE;
        else
            op.new_state = 3'($urandom_range(0, 7));
        op.stamp_wait = 1'($urandom_range(0, 1));
        op.level = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, set_lowest));
        // never make a slot that was never allocated eligible to run
        if (op.action == ACT_SET_STATE && !ever_alloc[op.slot] && op.new_state <= SS_ZOMBIE)
            op.new_state = SS_UNUSED;
        if ($urandom_range(0, 49) == 0)
            clock_now = $urandom();
        else
            clock_now = clock_now + 32'($urandom_range(0, 4000));
        op.now = clock_now;
        return op;
    endfunction

    task automatic random_run(int count, int hold_at);
        for (int n = 0; n < count; n++)
        begin
            // long receiver hold-off while requests keep coming
            if (n == hold_at)
                hold_flip <= ~hold_flip;
            offer(random_op());
        end
    endtask

    directed_row_t directed [] = '{
        // pass on an empty table finds nothing
        '{'{ACT_PASS, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd0}, 1'b1, '{RS_NONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_ALLOC, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd0}, 1'b1, '{RS_DONE, 6'd0, 32'd1, 4'd1}},
        '{'{ACT_ALLOC, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd0}, 1'b1, '{RS_DONE, 6'd1, 32'd2, 4'd1}},
        '{'{ACT_SET_STATE, 6'd0, SS_RUNNABLE, 1'b1, 4'd0, 32'd100}, 1'b1, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd1, SS_RUNNABLE, 1'b0, 4'd0, 32'd100}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_PASS, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd200}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_PASS, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd300}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        // state codes past zombie are refused
        '{'{ACT_SET_STATE, 6'd0, 3'd7, 1'b1, 4'd15, 32'hFFFFFFFF}, 1'b1, '{RS_BAD, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd0, 3'd6, 1'b0, 4'd0, 32'd0}, 1'b1, '{RS_BAD, 6'd0, 32'd0, 4'd0}},
        // level past the least urgent one is refused
        '{'{ACT_SET_LEVEL, 6'd0, SS_UNUSED, 1'b0, 4'd15, 32'd0}, 1'b1, '{RS_BAD, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_LEVEL, 6'd1, SS_UNUSED, 1'b0, 4'd0, 32'd0}, 1'b1, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_LEVEL, 6'd63, 3'd7, 1'b1, 4'd3, 32'd0}, 1'b1, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_RUN_END, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd0}, 1'b1, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        // unknown action codes
        '{'{3'd5, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd0}, 1'b1, '{RS_NONE, 6'd0, 32'd0, 4'd0}},
        '{'{3'd7, 6'd63, 3'd7, 1'b1, 4'd15, 32'hFFFFFFFF}, 1'b1, '{RS_NONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd1, SS_RUNNABLE, 1'b1, 4'd0, 32'd400}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd0, SS_RUNNABLE, 1'b0, 4'd0, 32'd400}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_PASS, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd500}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd0, SS_ZOMBIE, 1'b0, 4'd0, 32'd0}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd0, 3'd2, 1'b0, 4'd0, 32'd0}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd0, SS_RUNNING, 1'b0, 4'd0, 32'd0}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd0, SS_USED, 1'b0, 4'd0, 32'd0}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        '{'{ACT_SET_STATE, 6'd0, SS_UNUSED, 1'b1, 4'd0, 32'hFFFFFFFF}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}},
        // a freed slot is handed out again under a fresh id
        '{'{ACT_ALLOC, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'd0}, 1'b1, '{RS_DONE, 6'd0, 32'd3, 4'd1}},
        '{'{ACT_PASS, 6'd0, SS_UNUSED, 1'b0, 4'd0, 32'hFFFFFFFF}, 1'b0, '{RS_DONE, 6'd0, 32'd0, 4'd0}}
    };

    // main sequence
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_THRESHOLD;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_ALLOC;
        req_ch.slot       = '0;
        req_ch.new_state  = SS_UNUSED;
        req_ch.stamp_wait = 1'b0;
        req_ch.level      = '0;
        req_ch.now        = '0;
        hold_flip         = 1'b0;
        typed_ok          = 1'b0;
        typed_ans         = '{RS_DONE, 6'd0, 32'd0, 4'd0};
        mismatches        = 0;
        answers_seen      = 0;
        picks_seen        = 0;
        items_sent        = 0;
        burst_left        = 0;
        clock_now         = 32'd1000;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_state[i] = SS_UNUSED;
            shadow_cur[i]   = '0;
            shadow_base[i]  = '0;
            shadow_wait[i]  = '0;
            shadow_runs[i]  = '0;
            shadow_id[i]    = '0;
            ever_alloc[i]   = 1'b0;
        end
        shadow_next_id = 32'd1;
        last_pick_ok   = 1'b0;
        last_pick_slot = '0;
        shadow_passes  = '0;
        set_threshold  = 32'd1000000;
        set_period     = 16'd10;
        set_use_limit  = 16'd500;
        set_lowest     = 4'd3;
        set_highest    = 4'd0;
        set_default    = 4'd1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset settings
        foreach (directed[r])
        begin
            typed_ok  = directed[r].known_ans;
            typed_ans = directed[r].ans;
            offer(directed[r].op);
        end
        typed_ok = 1'b0;
        random_run(380, 150);
        drain();

        // fast aging, every level legal, table filled past capacity
        apply_settings(32'd0, 16'd1, 16'd0, 4'd15, 4'd0, 4'd15);
        for (int n = 0; n < 66; n++)
            offer('{ACT_ALLOC, 6'd0, SS_UNUSED, 1'b0, 4'd0, clock_now});
        random_run(320, -1);
        drain();

        // aging off, single legal level, nothing ever lowered
        apply_settings(32'hFFFFFFFF, 16'd65535, 16'd65535, 4'd0, 4'd15, 4'd0);
        random_run(330, 100);
        drain();

        // middle-of-the-road settings
        apply_settings(32'd3000, 16'd2, 16'd3, 4'd7, 4'd2, 4'd4);
        random_run(420, -1);

        drain();
        repeat (300) @(posedge clk);
        $display("covered %0d transactions, %0d responses, %0d with a slot handed out",
                 items_sent, answers_seen, picks_seen);
        $display("four register settings, table overflow, aging and round-robin rotation");
        if (mismatches == 0 && answers_due.size() == 0)
            $display("priority_aging_scheduler: match");
        else
            $display("priority_aging_scheduler: mismatch");
        $finish;
    end

endmodule
